// ===== rtl/core/mtg_pkg.sv =====
// Package for the MT19937 generator core: constants, controller states,
// command/status structs and the tempering and seeding functions.
// No dependencies.
package mtg_pkg;

  // Generator constants
  localparam int unsigned WordCount  = 624;
  localparam int unsigned TapOffset  = 397;
  localparam int unsigned AddrW      = $clog2(WordCount);
  localparam int unsigned WordW      = 32;

  localparam logic [31:0] TwistXor    = 32'h9908_b0df;
  localparam logic [31:0] HighBit     = 32'h8000_0000;
  localparam logic [31:0] LowBits     = 32'h7fff_ffff;
  localparam logic [31:0] SeedMult    = 32'd1812433253;
  localparam logic [31:0] DefaultSeed = 32'd5489;
  localparam logic [31:0] TemperB     = 32'h9d2c_5680;
  localparam logic [31:0] TemperC     = 32'hefc6_0000;

  // Input operation codes
  localparam logic OpDraw = 1'b0;
  localparam logic OpSeed = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_RD_K,
    ST_RD_N,
    ST_RD_T,
    ST_TWIST
  } mtg_state_e;

  // State memory read address select
  typedef enum logic [1:0] {
    RSEL_K,
    RSEL_N,
    RSEL_T
  } mtg_rsel_e;

  // Controller -> datapath
  typedef struct packed {
    logic      load_item;   // capture input transfer
    logic      seed_step;   // write one seeding word
    mtg_rsel_e rsel;        // read address select
    logic      latch_k;     // capture word at current position
    logic      latch_n;     // capture following word
    logic      twist_wr;    // write twisted word, load result
  } mtg_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic in_op_seed;   // operation field of the incoming transfer
    logic seeded;       // state memory holds a seeded state
    logic op_draw;      // latched item is a draw
    logic seed_last;    // seeding writes the last word this cycle
    logic out_free;     // result register can take a new word
  } mtg_status_t;

  // Output tempering
  function automatic logic [31:0] mtg_temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  // One step of the seeding recurrence
  function automatic logic [31:0] mtg_seed_next(input logic [31:0] prev,
                                                input logic [AddrW-1:0] idx);
    logic [31:0] prod;
    prod = SeedMult * (prev ^ (prev >> 30));
    return prod + {{(32-AddrW){1'b0}}, idx};
  endfunction

endpackage

// ===== rtl/core/mtg_if.sv =====
// Valid/ready stream interfaces for the generator's input and result channels.
// Depends on nothing.
interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] seed;

  modport source (output valid, output operation, output seed, input ready);
  modport sink   (input valid, input operation, input seed, output ready);
endinterface

interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ===== rtl/core/mtg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mtg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/mtg_datapath.sv =====
// Datapath of the generator: state memory, seeding recurrence, in-place
// twist of one word per draw, tempering and result register.
// Depends on mtg_pkg and mtg_ram.
module mtg_datapath import mtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        operation_i,
  input  logic [31:0] seed_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output logic [31:0] random_word_o,
  input  mtg_cmd_t    cmd_i,
  output mtg_status_t status_o
);

  logic             seeded_q, seeded_d;
  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             op_q;
  logic [31:0]      seed_q, prev_q, wk_q, wn_q, word_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [31:0]      mem_wdata, mem_rdata;
  logic [31:0]      seed_word, twist_word, y;
  logic [AddrW-1:0] pos_next, tap_addr, pos_last, idx_last;
  logic [AddrW:0]   tap_sum;

  assign pos_last = AddrW'(WordCount - 1);
  assign idx_last = AddrW'(WordCount - 1);

  // Neighbor and tap addresses, modulo the word count
  assign pos_next = (pos_q == pos_last) ? '0 : pos_q + AddrW'(1);
  assign tap_sum  = {1'b0, pos_q} + (AddrW+1)'(TapOffset);
  assign tap_addr = (tap_sum >= (AddrW+1)'(WordCount))
                    ? AddrW'(tap_sum - (AddrW+1)'(WordCount)) : tap_sum[AddrW-1:0];

  always_comb begin
    case (cmd_i.rsel)
      RSEL_K:  mem_raddr = pos_q;
      RSEL_N:  mem_raddr = pos_next;
      RSEL_T:  mem_raddr = tap_addr;
      default: mem_raddr = pos_q;
    endcase
  end

  // Seeding word: the seed itself at index zero, the recurrence after it
  assign seed_word = (idx_q == '0) ? seed_q : mtg_seed_next(prev_q, idx_q);

  // Twist of the word at the current position; rdata holds the tap word
  assign y          = (wk_q & HighBit) | (wn_q & LowBits);
  assign twist_word = mem_rdata ^ (y >> 1) ^ (y[0] ? TwistXor : 32'h0);

  assign mem_we    = cmd_i.seed_step | cmd_i.twist_wr;
  assign mem_waddr = cmd_i.seed_step ? idx_q : pos_q;
  assign mem_wdata = cmd_i.seed_step ? seed_word : twist_word;

  mtg_ram #(
    .Width (WordW),
    .Depth (WordCount)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Control register updates
  always_comb begin
    seeded_d    = seeded_q;
    pos_d       = pos_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    if (cmd_i.load_item) begin
      idx_d = '0;
    end
    if (cmd_i.seed_step) begin
      idx_d = idx_q + AddrW'(1);
      if (idx_q == idx_last) begin
        seeded_d = 1'b1;
        pos_d    = '0;
      end
    end
    if (cmd_i.twist_wr) begin
      pos_d       = pos_next;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seeded_q    <= 1'b0;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      idx_q       <= '0;
    end else begin
      seeded_q    <= seeded_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      idx_q       <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q   <= operation_i;
      seed_q <= (operation_i == OpSeed) ? seed_i : DefaultSeed;
    end
    if (cmd_i.seed_step) begin
      prev_q <= seed_word;
    end
    if (cmd_i.latch_k) begin
      wk_q <= mem_rdata;
    end
    if (cmd_i.latch_n) begin
      wn_q <= mem_rdata;
    end
    if (cmd_i.twist_wr) begin
      word_q <= mtg_temper(twist_word);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign random_word_o = word_q;

  assign status_o.in_op_seed = (operation_i == OpSeed);
  assign status_o.seeded     = seeded_q;
  assign status_o.op_draw    = (op_q == OpDraw);
  assign status_o.seed_last  = cmd_i.seed_step & (idx_q == idx_last);
  assign status_o.out_free   = ~out_valid_q | out_ready_i;

endmodule

// ===== rtl/core/mtg_controller.sv =====
// Controller state machine of the generator: sequences seeding and the
// three reads and one write of each draw.
// Depends on mtg_pkg.
module mtg_controller import mtg_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output mtg_cmd_t    cmd_o,
  input  mtg_status_t status_i
);

  mtg_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{load_item: 1'b0, seed_step: 1'b0, rsel: RSEL_K,
                   latch_k: 1'b0, latch_n: 1'b0, twist_wr: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          // a draw before any seed runs the default seeding first
          state_d = (status_i.in_op_seed || !status_i.seeded) ? ST_SEED : ST_RD_K;
        end
      end
      ST_SEED: begin
        cmd_o.seed_step = 1'b1;
        if (status_i.seed_last) begin
          state_d = status_i.op_draw ? ST_RD_K : ST_IDLE;
        end
      end
      ST_RD_K: begin
        cmd_o.rsel = RSEL_K;
        state_d    = ST_RD_N;
      end
      ST_RD_N: begin
        cmd_o.rsel    = RSEL_N;
        cmd_o.latch_k = 1'b1;
        state_d       = ST_RD_T;
      end
      ST_RD_T: begin
        cmd_o.rsel    = RSEL_T;
        cmd_o.latch_n = 1'b1;
        state_d       = ST_TWIST;
      end
      ST_TWIST: begin
        // hold the tap read until the result register frees up
        cmd_o.rsel = RSEL_T;
        if (status_i.out_free) begin
          cmd_o.twist_wr = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/mersenne_twister_generator_core.sv =====
// Top level of the MT19937 generator core: controller plus datapath.
// Depends on mtg_pkg, mtg_if, mtg_controller, mtg_datapath, mtg_ram.
//
//   channel  | dir | payload                    | transfer
//   ---------+-----+----------------------------+---------------------------
//   in_i     | in  | operation (1), seed (32)   | valid & ready, draw or seed
//   out_o    | out | random_word (32)           | valid & ready, one per draw
//
// A draw takes the accept cycle, three reads through the state memory's one read
// port and the write of the twisted word, which loads the result register. A seed
// takes the accept cycle and then one state word written per cycle; a draw before
// any seed runs that seeding first. Reset clears control only. A waiting result
// stalls the next draw only at its write; input reopens once an item is done.
module mersenne_twister_generator_core import mtg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  mtg_in_if.sink    in_i,
  mtg_out_if.source out_o
);

  mtg_cmd_t    cmd;
  mtg_status_t status;

  mtg_controller u_controller (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  mtg_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .operation_i   (in_i.operation),
    .seed_i        (in_i.seed),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .random_word_o (out_o.random_word),
    .cmd_i         (cmd),
    .status_o      (status)
  );

endmodule
